/* src/trajectory_state_sampler_macros.svh */
// assertion helpers included by tss_back
`ifndef TRAJECTORY_STATE_SAMPLER_MACROS_SVH
`define TRAJECTORY_STATE_SAMPLER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define TSS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tss_pkg.sv */
package tss_pkg;
    localparam int MaxPoints = 1024;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CountW    = AddrW + 1;
    localparam int NVals     = 9;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int ValsW = NVals * 32;

    typedef struct packed {
        logic              kind;
        logic              first_point;
        logic [31:0]       sample_time;
        logic [ValsW-1:0]  vals;
    } tss_item_t;
endpackage

/* src/tss_front.sv */
// input stage: registers items into a two-entry queue
module tss_front
    import tss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  tss_item_t in_item,
    output logic      q_valid,
    input  logic      q_ready,
    output tss_item_t q_item
);
    tss_item_t  slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= in_item;
        end
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* src/tss_divider.sv */
// restoring divider: 16 quotient bits of (num << 16) / den, num < den
module tss_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [15:0] quo
);
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [15:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] shifted;
    logic        ge;

    assign shifted = {rem_reg[31:0], 1'b0};
    assign ge      = shifted >= {1'b0, den_reg};
    assign quo     = quo_reg;
    assign done    = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
        end else if (busy_reg && cnt_reg != 5'd0) begin
            rem_reg <= ge ? shifted - {1'b0, den_reg} : shifted;
            quo_reg <= {quo_reg[14:0], ge};
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end else if (busy_reg) begin
            if (cnt_reg == 5'd0) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 5'd1;
        end
    end
endmodule

/* src/tss_back.sv */
// table, lower-bound search, ratio division and serial interpolation
module tss_back
    import tss_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [15:0]  time_epsilon,
    input  logic         q_valid,
    output logic         q_ready,
    input  tss_item_t    q_item,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [ValsW:0] res_data
);
    `include "trajectory_state_sampler_macros.svh"

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SRCH  = 4'd1;
    localparam logic [3:0] ST_SWAIT = 4'd2;
    localparam logic [3:0] ST_RD1   = 4'd3;
    localparam logic [3:0] ST_RD2   = 4'd4;
    localparam logic [3:0] ST_RAT   = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_LERP  = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [31:0] tmem [MaxPoints];
    logic [ValsW-1:0] vmem [MaxPoints];

    logic [3:0]        st_reg;
    logic [CountW-1:0] count_reg;
    logic [31:0]       total_reg;
    logic [31:0]       t_reg;
    logic [CountW-1:0] lo_reg, hi_reg;
    logic [AddrW-1:0]  raddr;
    logic [31:0]       trd_reg;
    logic [ValsW-1:0]  vrd_reg;
    logic [31:0]       t1_reg, t2_reg;
    logic [ValsW-1:0]  v1_reg, v2_reg;
    logic [AddrW-1:0]  i1_reg, i2_reg;
    logic [16:0]       ratio_reg;
    logic              flat_reg;
    logic [3:0]        idx_reg;
    logic [ValsW-1:0]  acc_reg;
    logic [47:0]       prod_reg;
    logic              neg_reg;
    logic              res_valid_reg;
    logic [ValsW:0]    res_reg;

    logic [CountW-1:0] mid;
    logic [CountW-1:0] sel1, sel2;
    logic [32:0]       den_s, num_s;
    logic [31:0]       aden, anum;
    logic              flat_now;
    logic              div_start, div_done;
    logic [15:0]       div_q;
    logic [31:0]       va, vb;
    logic [32:0]       diff;
    logic [31:0]       mag;
    logic [31:0]       term;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign q_ready = (st_reg == ST_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_comb begin
        if (lo_reg == '0) begin
            sel1 = '0;
            sel2 = (count_reg > 1) ? CountW'(1) : '0;
        end else if (lo_reg >= count_reg) begin
            sel1 = count_reg - ((count_reg > 1) ? CountW'(2) : CountW'(1));
            sel2 = count_reg - CountW'(1);
        end else begin
            sel1 = lo_reg - CountW'(1);
            sel2 = lo_reg;
        end
    end

    // first point read in RD1, second point read in RD2
    always_comb begin
        unique case (st_reg)
            ST_SRCH: raddr = mid[AddrW-1:0];
            ST_RD1:  raddr = i1_reg;
            default: raddr = i2_reg;
        endcase
    end

    assign den_s = {1'b0, t2_reg} - {1'b0, t1_reg};
    assign num_s = {1'b0, t_reg} - {1'b0, t1_reg};
    assign aden  = den_s[32] ? 32'(-den_s) : den_s[31:0];
    assign anum  = num_s[32] ? 32'(-num_s) : num_s[31:0];
    assign flat_now  = (aden == '0) || (aden < {16'd0, time_epsilon});
    assign div_start = (st_reg == ST_DIV) && !flat_now && (num_s != '0)
                       && (num_s[32] == den_s[32]) && (anum < aden);

    tss_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (anum),
        .den    (aden),
        .done   (div_done),
        .quo    (div_q)
    );

    assign va   = v1_reg[idx_reg*32 +: 32];
    assign vb   = v2_reg[idx_reg*32 +: 32];
    assign diff = {vb[31], vb} - {va[31], va};
    assign mag  = diff[32] ? 32'(-diff) : diff[31:0];
    assign term = prod_reg[47:16];

    always_ff @(posedge aclk) begin
        trd_reg <= tmem[raddr];
        vrd_reg <= vmem[raddr];
        if (q_valid && q_ready && q_item.kind == KIND_LOAD) begin
            if (q_item.first_point || count_reg < CountW'(MaxPoints)) begin
                tmem[q_item.first_point ? '0 : count_reg[AddrW-1:0]] <= q_item.sample_time;
                vmem[q_item.first_point ? '0 : count_reg[AddrW-1:0]] <= q_item.vals;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (q_valid && q_ready) begin
                        if (q_item.kind == KIND_LOAD) begin
                            if (q_item.first_point) begin
                                count_reg <= CountW'(1);
                                total_reg <= q_item.sample_time;
                            end else if (count_reg < CountW'(MaxPoints)) begin
                                count_reg <= count_reg + CountW'(1);
                                total_reg <= q_item.sample_time;
                            end
                        end else if (count_reg == '0) begin
                            res_reg       <= '0;
                            res_valid_reg <= 1'b1;
                        end else begin
                            t_reg  <= (q_item.sample_time > total_reg) ? total_reg
                                                                       : q_item.sample_time;
                            lo_reg <= '0;
                            hi_reg <= count_reg;
                            st_reg <= ST_SRCH;
                        end
                    end
                end
                ST_SRCH: begin
                    if (lo_reg < hi_reg) st_reg <= ST_SWAIT;
                    else begin
                        i1_reg <= sel1[AddrW-1:0];
                        i2_reg <= sel2[AddrW-1:0];
                        st_reg <= ST_RD1;
                    end
                end
                ST_SWAIT: begin
                    // trd_reg holds time at mid
                    if (trd_reg < t_reg) lo_reg <= mid + CountW'(1);
                    else hi_reg <= mid;
                    st_reg <= ST_SRCH;
                end
                ST_RD1: st_reg <= ST_RD2;
                ST_RD2: begin
                    t1_reg <= trd_reg;
                    v1_reg <= vrd_reg;
                    st_reg <= ST_RAT;
                end
                ST_RAT: begin
                    // t2 arrives now; flat test uses it next
                    t2_reg <= trd_reg;
                    v2_reg <= vrd_reg;
                    st_reg <= ST_DIV;
                end
                default: ;
            endcase
            // divider is started in this step when a real quotient is needed
            if (st_reg == ST_DIV) begin
                flat_reg  <= flat_now;
                st_reg    <= ST_LERP;
                ratio_reg <= '0;
                idx_reg   <= '0;
            end
            if (st_reg == ST_LERP) begin
                if (flat_reg) begin
                    res_reg       <= {v1_reg, 1'b1};
                    res_valid_reg <= 1'b1;
                    st_reg        <= ST_IDLE;
                end else if (num_s == '0 || num_s[32] != den_s[32]) begin
                    ratio_reg <= '0;
                    st_reg    <= ST_MUL;
                end else if (anum >= aden) begin
                    ratio_reg <= 17'h10000;
                    st_reg    <= ST_MUL;
                end else if (div_done) begin
                    ratio_reg <= {1'b0, div_q};
                    st_reg    <= ST_MUL;
                end
            end
            if (st_reg == ST_MUL) begin
                prod_reg <= 48'(mag) * 48'(ratio_reg);
                neg_reg  <= diff[32];
                st_reg   <= ST_OUT;
            end
            if (st_reg == ST_OUT) begin
                acc_reg[idx_reg*32 +: 32] <= neg_reg ? va - term : va + term;
                if (idx_reg == 4'(NVals - 1)) begin
                    res_reg       <= {acc_reg[ValsW-1:(NVals-1)*32] & '0 |
                                      {neg_reg ? va - term : va + term},
                                      acc_reg[(NVals-1)*32-1:0], 1'b1};
                    res_valid_reg <= 1'b1;
                    st_reg        <= ST_IDLE;
                end else begin
                    idx_reg <= idx_reg + 4'd1;
                    st_reg  <= ST_MUL;
                end
            end
        end
    end

    `TSS_ASSERT_IMP(a_no_result_when_busy, aclk, aresetn,
        (st_reg != ST_IDLE) && (st_reg != ST_OUT) && (st_reg != ST_LERP), !$rose(res_valid_reg),
        "result raised outside final step")
    `TSS_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1,
        count_reg <= CountW'(MaxPoints), "point count beyond capacity")
    `TSS_ASSERT_NEXT(a_query_empty, aclk, aresetn,
        q_valid && q_ready && q_item.kind == KIND_QUERY && count_reg == '0,
        res_valid_reg && !res_reg[0], "empty-table query must fail at once")
endmodule

/* src/trajectory_state_sampler.sv */
// a load is written into the table when the back end takes it from the input queue; a query
// result follows s halving steps of the search (at most 11), the two point reads, the
// 16-step ratio divider and one multiply pass per value (9 values); the divide is skipped
// when no real quotient is needed, and a flat interval returns the first point's values
// throughput: one query at a time, empty-table query skips the search, loads 1 per cycle when idle
// reset: aresetn synchronous active low clears count, duration, epsilon to 1
module trajectory_state_sampler
    import tss_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         time_epsilon_we,
    input  logic [15:0]  time_epsilon_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sample_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
    input  logic [319:0] s_tdata,
    // kind, first_point
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_pos_x .. out_acc_z
    output logic [287:0] m_tdata,
    // ok
    output logic         m_tuser
);
    logic [15:0]    eps_reg;
    tss_item_t      in_item, q_item;
    logic           q_valid, q_ready;
    logic [ValsW:0] res;

    always_ff @(posedge aclk) begin
        if (!aresetn) eps_reg <= 16'd1;
        else if (time_epsilon_we) eps_reg <= time_epsilon_wdata;
    end

    assign in_item.kind        = s_tuser[0];
    assign in_item.first_point = s_tuser[1];
    assign in_item.sample_time = s_tdata[31:0];
    assign in_item.vals        = s_tdata[319:32];

    tss_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    tss_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .time_epsilon(eps_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_data    (res)
    );

    assign m_tuser = res[0];
    assign m_tdata = res[ValsW:1];
endmodule
